// ===== hdl/pbme_pkg.sv =====
// ----------------------------------------------------------------------------
// pbme_pkg
// Shared widths, register codes, reset values and status types of the pulse
// baseline and minimum extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package pbme_pkg;

   // longest record that takes part in minimum and baseline
   localparam int MAX_RECORD = 1024;

   localparam int SAMPLE_W   = 12;
   localparam int MIN_W      = SAMPLE_W + 1;
   localparam int IDX_W      = $clog2(MAX_RECORD + 1);
   localparam int SUM_W      = SAMPLE_W + IDX_W;
   localparam int WINDOW_W   = 16;
   localparam int OUT_IDX_W  = 16;
   localparam int AMP_W      = 13;
   localparam int STEP_W     = $clog2(SAMPLE_W + 1);

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALFWIDTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW    = 2'd2;

   // reset values
   localparam logic [SAMPLE_W-1:0] CENTER_RESET    = 12'd2048;
   localparam logic [SAMPLE_W-1:0] HALFWIDTH_RESET = 12'd10;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET    = 16'd306;
   localparam logic [MIN_W-1:0]    MIN_RESET       = 13'd4096;

   typedef struct packed {
      logic [SAMPLE_W-1:0] center;
      logic [SAMPLE_W-1:0] halfwidth;
      logic [WINDOW_W-1:0] window;
   } band_cfg_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [IDX_W-1:0] count;
      logic [MIN_W-1:0] minimum;
      logic [IDX_W-1:0] min_index;
   } acc_state_type;

endpackage

`default_nettype wire

// ===== hdl/pbme_req_if.sv =====
// ----------------------------------------------------------------------------
// pbme_req_if
// Sample channel: one waveform sample per item, last flag closes the record.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbme_req_if;
   import pbme_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic                last;

   modport source (output valid, sample, last, input ready);
   modport sink   (input valid, sample, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/pbme_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pbme_rsp_if
// Result channel: one item per record with mean, minimum and amplitude.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbme_rsp_if;
   import pbme_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [SAMPLE_W-1:0]     baseline_mean;
   logic [SAMPLE_W-1:0]     minimum;
   logic [OUT_IDX_W-1:0]    minimum_index;
   logic signed [AMP_W-1:0] amplitude;
   logic                    no_baseline;

   modport source (output valid, baseline_mean, minimum, minimum_index, amplitude,
                   no_baseline, input ready);
   modport sink   (input valid, baseline_mean, minimum, minimum_index, amplitude,
                   no_baseline, output ready);
endinterface

`default_nettype wire

// ===== hdl/pulse_baseline_and_minimum_extractor.sv =====
// ----------------------------------------------------------------------------
// pulse_baseline_and_minimum_extractor
// Tracks minimum and baseline over a waveform record and reports mean,
// minimum, its index and amplitude after the last sample arrives.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake        payload
//   req_ch    in          valid / ready    sample, last
//   rsp_ch    out         valid / ready    baseline_mean, minimum, minimum_index,
//                                          amplitude, no_baseline
//   csr_*     in          write enable     csr_index, csr_write_data
//
// Samples are taken one per cycle inside a record.
// After the last sample the block passes a launch state and then the divider
// (twelve bit-serial steps and then its done flag; skipped with no baseline),
// then holds the result until taken; req_ch.ready is low from the cycle after
// the last sample until then.
// Synchronous active-high reset loads the register defaults and clears the
// record state.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_baseline_and_minimum_extractor (
   input  wire logic                          clock,
   input  wire logic                          reset,
   pbme_req_if.sink                           req_ch,
   pbme_rsp_if.source                         rsp_ch,
   input  wire logic                          csr_write_en,
   input  wire logic [pbme_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pbme_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import pbme_pkg::*;

   localparam logic [1:0] ST_COLLECT = 2'd0;
   localparam logic [1:0] ST_LAUNCH  = 2'd1;
   localparam logic [1:0] ST_DIVIDE  = 2'd2;
   localparam logic [1:0] ST_RESULT  = 2'd3;

   logic [1:0] state_ff, state_in;

   band_cfg_type cfg_ff, cfg_in;

   logic [SAMPLE_W-1:0]     mean_ff, mean_in;
   logic [SAMPLE_W-1:0]     minv_ff, minv_in;
   logic [OUT_IDX_W-1:0]    mindex_ff, mindex_in;
   logic signed [AMP_W-1:0] amp_ff, amp_in;
   logic                    none_ff, none_in;

   acc_state_type       acc;
   logic                take;
   logic                clear;
   logic                div_start;
   logic                div_done;
   logic [SAMPLE_W-1:0] div_quotient;

   assign take = req_ch.valid && req_ch.ready;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_CENTER:    cfg_in.center    = csr_write_data[SAMPLE_W-1:0];
            CSR_HALFWIDTH: cfg_in.halfwidth = csr_write_data[SAMPLE_W-1:0];
            CSR_WINDOW:    cfg_in.window    = csr_write_data[WINDOW_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   // record tracker
   pbme_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .sample (req_ch.sample),
      .clear  (clear),
      .cfg    (cfg_ff),
      .acc    (acc)
   );

   // mean divider
   pbme_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc.sum),
      .divisor  (acc.count),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // control sequence and result register
   always_comb begin
      state_in  = state_ff;
      mean_in   = mean_ff;
      minv_in   = minv_ff;
      mindex_in = mindex_ff;
      amp_in    = amp_ff;
      none_in   = none_ff;
      clear     = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_COLLECT: begin
            if (take && req_ch.last) begin
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            // snapshot the record, then clear it for the next one
            minv_in   = acc.minimum[SAMPLE_W-1:0];
            mindex_in = OUT_IDX_W'(acc.min_index);
            none_in   = (acc.count == '0);
            mean_in   = '0;
            amp_in    = '0;
            clear     = 1'b1;
            if (acc.count == '0) begin
               state_in = ST_RESULT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               mean_in  = div_quotient;
               amp_in   = $signed({1'b0, div_quotient}) - $signed({1'b0, minv_ff});
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_ch.ready) begin
               state_in = ST_COLLECT;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_COLLECT;
         cfg_ff.center    <= CENTER_RESET;
         cfg_ff.halfwidth <= HALFWIDTH_RESET;
         cfg_ff.window    <= WINDOW_RESET;
      end else begin
         state_ff <= state_in;
         cfg_ff   <= cfg_in;
      end
      mean_ff   <= mean_in;
      minv_ff   <= minv_in;
      mindex_ff <= mindex_in;
      amp_ff    <= amp_in;
      none_ff   <= none_in;
   end

   // channel outputs
   assign req_ch.ready         = (state_ff == ST_COLLECT);
   assign rsp_ch.valid         = (state_ff == ST_RESULT);
   assign rsp_ch.baseline_mean = mean_ff;
   assign rsp_ch.minimum       = minv_ff;
   assign rsp_ch.minimum_index = mindex_ff;
   assign rsp_ch.amplitude     = amp_ff;
   assign rsp_ch.no_baseline   = none_ff;

endmodule

`default_nettype wire

// ===== hdl/pbme_accum.sv =====
// ----------------------------------------------------------------------------
// pbme_accum
// Per-sample tracker: running minimum with first index, and sum and count of
// early samples strictly inside the baseline band.
// ----------------------------------------------------------------------------
`default_nettype none

module pbme_accum (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    take,
   input  wire logic [pbme_pkg::SAMPLE_W-1:0] sample,
   input  wire logic                    clear,
   input  wire pbme_pkg::band_cfg_type  cfg,
   output pbme_pkg::acc_state_type      acc
);
   import pbme_pkg::*;

   logic [IDX_W-1:0] index_ff, index_in;
   logic [MIN_W-1:0] min_ff, min_in;
   logic [IDX_W-1:0] min_idx_ff, min_idx_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [IDX_W-1:0] count_ff, count_in;

   logic active;
   logic above_lo;
   logic below_hi;
   logic in_window;
   logic is_base;

   // band test without wrap: s > c - h  <=>  s + h > c
   assign above_lo  = ({1'b0, sample} + {1'b0, cfg.halfwidth}) > {1'b0, cfg.center};
   assign below_hi  = {1'b0, sample} < ({1'b0, cfg.center} + {1'b0, cfg.halfwidth});
   assign in_window = 32'(index_ff) < 32'(cfg.window);
   assign active    = index_ff < IDX_W'(MAX_RECORD);
   assign is_base   = above_lo && below_hi && in_window;

   // next record state
   always_comb begin
      index_in   = index_ff;
      min_in     = min_ff;
      min_idx_in = min_idx_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      if (clear) begin
         index_in   = '0;
         min_in     = MIN_RESET;
         min_idx_in = '0;
         sum_in     = '0;
         count_in   = '0;
      end else if (take && active) begin
         if ({1'b0, sample} < min_ff) begin
            min_in     = {1'b0, sample};
            min_idx_in = index_ff;
         end
         if (is_base) begin
            sum_in   = sum_ff + SUM_W'(sample);
            count_in = count_ff + 1'b1;
         end
         index_in = index_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff   <= '0;
         min_ff     <= MIN_RESET;
         min_idx_ff <= '0;
         sum_ff     <= '0;
         count_ff   <= '0;
      end else begin
         index_ff   <= index_in;
         min_ff     <= min_in;
         min_idx_ff <= min_idx_in;
         sum_ff     <= sum_in;
         count_ff   <= count_in;
      end
   end

   assign acc.sum       = sum_ff;
   assign acc.count     = count_ff;
   assign acc.minimum   = min_ff;
   assign acc.min_index = min_idx_ff;

endmodule

`default_nettype wire

// ===== hdl/pbme_div.sv =====
// ----------------------------------------------------------------------------
// pbme_div
// Restoring divider: one quotient bit per cycle from a shared subtractor,
// twelve steps for the baseline mean.
// ----------------------------------------------------------------------------
`default_nettype none

module pbme_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [pbme_pkg::SUM_W-1:0]   dividend,
   input  wire logic [pbme_pkg::IDX_W-1:0]   divisor,
   output logic                              done,
   output logic [pbme_pkg::SAMPLE_W-1:0]     quotient
);
   import pbme_pkg::*;

   logic [IDX_W-1:0]    rem_ff, rem_in;
   logic [SAMPLE_W-1:0] quo_ff, quo_in;
   logic [IDX_W-1:0]    dsr_ff, dsr_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [IDX_W:0] trial;
   logic [IDX_W:0] diff;
   logic           fits;

   // shared compare and subtract
   assign trial = {rem_ff, quo_ff[SAMPLE_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   // sequencer: the quotient is below 2^12, so the high part seeds the remainder
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend[SUM_W-1:SAMPLE_W];
         quo_in  = dividend[SAMPLE_W-1:0];
         dsr_in  = divisor;
         step_in = STEP_W'(SAMPLE_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
         quo_in  = {quo_ff[SAMPLE_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire
